// ----- hw/rtl/stu_pkg.sv -----
// Shared types and constants of the string to unsigned 32-bit parser.
package stu_pkg;

  localparam int CharW   = 8;
  localparam int DigitW  = 6;
  localparam int BaseW   = 6;
  localparam int ValueW  = 32;
  localparam int OffsetW = 16;

  // Digit code of a byte that is no digit in any base; it is at least every base.
  localparam logic [DigitW-1:0] NotDigit = '1;

  localparam logic [BaseW-1:0] AutoBase    = 6'd0;
  localparam logic [BaseW-1:0] BinBase     = 6'd2;
  localparam logic [BaseW-1:0] OctBase     = 6'd8;
  localparam logic [BaseW-1:0] DecBase     = 6'd10;
  localparam logic [BaseW-1:0] HexBase     = 6'd16;
  localparam logic [BaseW-1:0] MaxBase     = 6'd36;
  localparam logic [BaseW-1:0] BadLowBase  = 6'd1;
  localparam logic [BaseW-1:0] RadixReset  = 6'd10;

  // Register word index of the radix register.
  localparam logic RegRadix = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } stu_phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADBASE = 2'd1,
    ST_RANGE   = 2'd2
  } stu_status_e;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic              start;
    logic              space;
    logic              minus;
    logic              plus;
    logic              zero;
    logic              x_char;
    logic              b_char;
    logic [DigitW-1:0] digit;
  } stu_class_t;

endpackage

// ----- hw/rtl/stu_front.sv -----
// Front end: accepts characters and classifies them for the parser.
module stu_front
  import stu_pkg::*;
(
  input  logic             s_tvalid_i,
  input  logic [CharW-1:0] s_tdata_i,
  input  logic             s_tuser_i,
  input  logic             full_i,
  output logic             s_tready_o,
  output logic             push_o,
  output stu_class_t       cls_o
);

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpB   = 8'h42;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoB   = 8'h62;
  localparam logic [CharW-1:0] ChLoX   = 8'h78;
  localparam logic [CharW-1:0] ChLoZ   = 8'h7A;
  localparam logic [CharW-1:0] LetterBias = 8'd10;

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  always_comb begin
    cls_o.start  = s_tuser_i;
    cls_o.space  = (s_tdata_i == ChSpace) || (s_tdata_i >= ChTab && s_tdata_i <= ChCr);
    cls_o.minus  = (s_tdata_i == ChMinus);
    cls_o.plus   = (s_tdata_i == ChPlus);
    cls_o.zero   = (s_tdata_i == Ch0);
    cls_o.x_char = (s_tdata_i == ChLoX) || (s_tdata_i == ChUpX);
    cls_o.b_char = (s_tdata_i == ChLoB) || (s_tdata_i == ChUpB);
    if (s_tdata_i >= Ch0 && s_tdata_i <= Ch9) begin
      cls_o.digit = DigitW'(s_tdata_i - Ch0);
    end else if (s_tdata_i >= ChUpA && s_tdata_i <= ChUpZ) begin
      cls_o.digit = DigitW'(s_tdata_i - ChUpA + LetterBias);
    end else if (s_tdata_i >= ChLoA && s_tdata_i <= ChLoZ) begin
      cls_o.digit = DigitW'(s_tdata_i - ChLoA + LetterBias);
    end else begin
      cls_o.digit = NotDigit;
    end
  end

endmodule

// ----- hw/rtl/stu_fifo.sv -----
// Short queue of classified characters between front and back.
module stu_fifo
  import stu_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  stu_class_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output stu_class_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  stu_class_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/stu_back.sv -----
// Back end: parse state machine, multiply-accumulate and result register.
module stu_back
  import stu_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BaseW-1:0]   radix_i,
  input  logic               ent_valid_i,
  input  stu_class_t         ent_i,
  output logic               ent_pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [ValueW-1:0]  value_o,
  output logic [1:0]         status_o,
  output logic [OffsetW-1:0] end_offset_o
);

  localparam int PosExtW = (POSITION_BITS > OffsetW) ? POSITION_BITS : OffsetW;
  localparam int MacW    = ValueW + BaseW;

  stu_phase_e                phase_q, phase_d;
  logic [ValueW-1:0]         acc_q, acc_d;
  logic [BaseW-1:0]          base_q, base_d;
  logic                      neg_q, neg_d;
  logic                      ovf_q, ovf_d;
  logic                      dig_q, dig_d;
  logic [POSITION_BITS-1:0]  pos_q, pos_d;

  logic                      m_tvalid_q;
  logic [ValueW-1:0]         value_q, res_value;
  stu_status_e               status_q, res_status;
  logic [OffsetW-1:0]        offset_q, res_offset;
  logic                      emit;

  logic                      adv, first, go_digit, bad_base;
  logic [BaseW-1:0]          use_base;
  logic [MacW-1:0]           mac;
  logic [PosExtW-1:0]        pos_ext;

  // Hold only an item that produces a result while the previous one still waits.
  assign ent_pop_o    = ent_valid_i && (!emit || !m_tvalid_q || m_tready_i);
  assign m_tvalid_o   = m_tvalid_q;
  assign value_o      = value_q;
  assign status_o     = status_q;
  assign end_offset_o = offset_q;

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    base_d     = base_q;
    neg_d      = neg_q;
    ovf_d      = ovf_q;
    dig_d      = dig_q;
    pos_d      = pos_q;
    emit       = 1'b0;
    res_value  = '0;
    res_status = ST_OK;
    res_offset = '0;
    adv        = 1'b0;
    first      = 1'b0;
    go_digit   = 1'b0;
    bad_base   = 1'b0;

    // A start clears the parse and samples the radix.
    if (ent_i.start) begin
      acc_d = '0;
      neg_d = 1'b0;
      ovf_d = 1'b0;
      dig_d = 1'b0;
      pos_d = '0;
      if (radix_i == BadLowBase || radix_i > MaxBase) begin
        bad_base   = 1'b1;
        base_d     = AutoBase;
        phase_d    = PH_IDLE;
        emit       = 1'b1;
        res_status = ST_BADBASE;
      end else begin
        base_d  = radix_i;
        phase_d = PH_SPACE;
      end
    end

    if (!bad_base) begin
      unique case (phase_d)
        PH_SPACE: begin
          if (ent_i.space) begin
            adv = 1'b1;
          end else if (ent_i.minus || ent_i.plus) begin
            neg_d   = ent_i.minus;
            phase_d = PH_SIGNED;
            adv     = 1'b1;
          end else begin
            first = 1'b1;
          end
        end
        PH_SIGNED: first = 1'b1;
        PH_ZERO: begin
          if ((base_d == AutoBase || base_d == HexBase) && ent_i.x_char) begin
            base_d  = HexBase;
            phase_d = PH_DIGITS;
            adv     = 1'b1;
          end else if ((base_d == AutoBase || base_d == BinBase) && ent_i.b_char) begin
            base_d  = BinBase;
            phase_d = PH_DIGITS;
            adv     = 1'b1;
          end else begin
            if (base_d == AutoBase) begin
              base_d = OctBase;
            end
            dig_d    = 1'b1;
            phase_d  = PH_DIGITS;
            go_digit = 1'b1;
          end
        end
        PH_DIGITS: go_digit = 1'b1;
        default: ;
      endcase
    end

    // First character after whitespace and sign: a zero may open a prefix.
    if (first) begin
      if (ent_i.zero && (base_d == AutoBase || base_d == HexBase || base_d == BinBase)) begin
        phase_d = PH_ZERO;
        adv     = 1'b1;
      end else begin
        if (base_d == AutoBase) begin
          base_d = DecBase;
        end
        phase_d  = PH_DIGITS;
        go_digit = 1'b1;
      end
    end

    use_base = (base_d >= BinBase && base_d <= MaxBase) ? base_d : DecBase;
    mac      = MacW'(acc_d) * MacW'(use_base) + MacW'(ent_i.digit);
    pos_ext  = PosExtW'(pos_d);

    if (go_digit) begin
      if (ent_i.digit >= use_base) begin
        // Not a digit in this base: the number ends here.
        emit       = 1'b1;
        res_value  = ovf_d ? '1 : (neg_d ? ValueW'(0) - acc_d : acc_d);
        res_status = ovf_d ? ST_RANGE : ST_OK;
        res_offset = dig_d ? pos_ext[OffsetW-1:0] : '0;
        phase_d    = PH_IDLE;
      end else begin
        if (mac[MacW-1:ValueW] != '0) begin
          ovf_d = 1'b1;
        end else if (!ovf_d) begin
          acc_d = mac[ValueW-1:0];
          dig_d = 1'b1;
        end
        adv = 1'b1;
      end
    end

    // Advance the position, saturating at all ones.
    if (adv && pos_d != '1) begin
      pos_d = pos_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      base_q  <= AutoBase;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      dig_q   <= 1'b0;
      pos_q   <= '0;
    end else if (ent_pop_o) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      dig_q   <= dig_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (ent_pop_o && emit) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_pop_o && emit) begin
      value_q  <= res_value;
      status_q <= res_status;
      offset_q <= res_offset;
    end
  end

  a_badbase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_q && status_q == ST_BADBASE |-> value_q == '0 && offset_q == '0)
    else $error("invalid-base result carries data");

  a_range_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_q && status_q == ST_RANGE |-> value_q == '1)
    else $error("out-of-range result is not saturated");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_q && !m_tready_i |=> m_tvalid_q && $stable(value_q) && $stable(offset_q))
    else $error("waiting result was dropped or changed");

  a_ovf_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> phase_q == PH_DIGITS || phase_q == PH_IDLE)
    else $error("overflow flag set outside the digit phase");

endmodule

// ----- hw/rtl/string_to_unsigned32_unit.sv -----
// Top level of the streaming string to unsigned 32-bit number parser.
//
// Feed one character per item on the slave stream, with tuser high on the
// first character of each string. After a start the unit skips C whitespace,
// takes one optional sign, honors the 0x/0X, 0b/0B and octal leading-zero
// prefixes, then accumulates digits in the selected base. The first
// character that is not a digit of that base ends the number and produces
// exactly one result item: the value (negated modulo 2^32 after a minus,
// all ones with status out-of-range on overflow), the status and the end
// offset (count of characters up to and including the last digit, 0 when
// no digit was taken). A start with radix 1 or above 36 produces one
// invalid-base result immediately. Characters outside a string and strings
// abandoned by a new start produce nothing. The radix register (APB word 0,
// reset 10, 0 = auto-detect) is sampled at each start; write it only while
// the unit is idle. Rate: one character per clock cycle sustained while
// results are taken, set by the back end's combinational multiply-accumulate
// and overflow test; a result item goes into the output register when the
// back takes the character that ends the number from the queue. The front
// classifies characters into a two-entry queue, and the back holds its
// result in an output register, so an input stall never stops the back, and
// a stalled result only holds back the next character that ends a number.
module string_to_unsigned32_unit
  import stu_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] start_req
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] value, [47:32] end_offset
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [BaseW-1:0]   radix_q;
  logic               cfg_wr;

  logic               fifo_full, fifo_push, fifo_valid, fifo_pop;
  stu_class_t         front_cls, back_cls;

  logic [ValueW-1:0]  res_value;
  logic [OffsetW-1:0] res_offset;

  // Register file: radix only, taken from the low bits of the write data.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegRadix) ? 32'(radix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_wr && paddr[2] == RegRadix) begin
      radix_q <= pwdata[BaseW-1:0];
    end
  end

  stu_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .full_i     (fifo_full),
    .s_tready_o (s_axis_tready),
    .push_o     (fifo_push),
    .cls_o      (front_cls)
  );

  stu_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_cls),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (back_cls)
  );

  stu_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_i      (radix_q),
    .ent_valid_i  (fifo_valid),
    .ent_i        (back_cls),
    .ent_pop_o    (fifo_pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .value_o      (res_value),
    .status_o     (m_axis_tuser),
    .end_offset_o (res_offset)
  );

  assign m_axis_tdata = {res_offset, res_value};

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the string to unsigned 32-bit parser: directed and random text.
module testbench
  import stu_pkg::*;
();

  // Byte address of the radix register on the configuration port.
  localparam logic [2:0] RadixAddr = {RegRadix, 2'b00};

  // One parsed number as the unit reports it.
  typedef struct packed {
    logic [ValueW-1:0]  value;
    stu_status_e        status;
    logic [OffsetW-1:0] offset;
  } number_t;

  // Track the parse character by character and hold the numbers still owed by the unit.
  class parse_tracker;
    logic [BaseW-1:0]   radix = RadixReset;
    stu_phase_e         phase = PH_IDLE;
    logic [ValueW-1:0]  acc = '0;
    logic [BaseW-1:0]   base = AutoBase;
    bit                 neg, ovf, got_digit;
    logic [OffsetW-1:0] pos = '0;
    number_t            owed[$];
    int unsigned        mismatches, checked;

    // Saturate at the top of the offset range.
    function void bump();
      if (pos != '1) pos++;
    endfunction

    function logic [DigitW-1:0] digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return DigitW'(c - "0");
      if (c >= "A" && c <= "Z") return DigitW'(c - "A" + 10);
      if (c >= "a" && c <= "z") return DigitW'(c - "a" + 10);
      return NotDigit;
    endfunction

    // Accumulate one digit, or close the number on the first non-digit.
    function void take_digit(logic [7:0] c);
      logic [31:0] b, d, lim_q, lim_r;
      number_t     n;
      b = (base >= BinBase && base <= MaxBase) ? 32'(base) : 32'(DecBase);
      d = 32'(digit_of(c));
      if (d >= b) begin
        n.value  = ovf ? '1 : (neg ? -acc : acc);
        n.status = ovf ? ST_RANGE : ST_OK;
        n.offset = got_digit ? pos : '0;
        owed.push_back(n);
        phase = PH_IDLE;
        return;
      end
      lim_q = 32'hFFFF_FFFF / b;
      lim_r = 32'hFFFF_FFFF % b;
      // Freeze the accumulator once it would wrap; keep consuming digits.
      if (acc > lim_q || (acc == lim_q && d > lim_r)) begin
        ovf = 1'b1;
      end else if (!ovf) begin
        acc = acc * b + d;
        got_digit = 1'b1;
      end
      bump();
    endfunction

    // First character after whitespace and sign: a zero may open a prefix.
    function void take_first(logic [7:0] c);
      if (c == "0" && (base == AutoBase || base == HexBase || base == BinBase)) begin
        phase = PH_ZERO;
        bump();
        return;
      end
      if (base == AutoBase) base = DecBase;
      phase = PH_DIGITS;
      take_digit(c);
    endfunction

    function void note_char(logic [7:0] c, logic opens);
      number_t n;
      if (opens) begin
        acc = '0;
        neg = 1'b0;
        ovf = 1'b0;
        got_digit = 1'b0;
        pos = '0;
        if (radix == BadLowBase || radix > MaxBase) begin
          base = AutoBase;
          phase = PH_IDLE;
          n.value = '0;
          n.status = ST_BADBASE;
          n.offset = '0;
          owed.push_back(n);
          return;
        end
        base = radix;
        phase = PH_SPACE;
      end
      case (phase)
        PH_SPACE: begin
          if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            bump();
          end else if (c == "-" || c == "+") begin
            neg = (c == "-");
            phase = PH_SIGNED;
            bump();
          end else begin
            take_first(c);
          end
        end
        PH_SIGNED: take_first(c);
        PH_ZERO: begin
          if ((base == AutoBase || base == HexBase) && (c == "x" || c == "X")) begin
            base = HexBase;
            phase = PH_DIGITS;
            bump();
          end else if ((base == AutoBase || base == BinBase) && (c == "b" || c == "B")) begin
            base = BinBase;
            phase = PH_DIGITS;
            bump();
          end else begin
            // A lone zero counts as a digit in its own right; in auto mode it selects octal.
            if (base == AutoBase) base = OctBase;
            got_digit = 1'b1;
            phase = PH_DIGITS;
            take_digit(c);
          end
        end
        PH_DIGITS: take_digit(c);
        default: ;
      endcase
    endfunction

    function void check_number(logic [ValueW-1:0] value, logic [1:0] status,
                               logic [OffsetW-1:0] offset);
      number_t n;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        $error("unexpected result: value %h status %0d end_offset %0d", value, status, offset);
        return;
      end
      n = owed.pop_front();
      if (value !== n.value) begin
        mismatches++;
        $error("value: expected %h, got %h", n.value, value);
      end
      if (status !== n.status) begin
        mismatches++;
        $error("status: expected %0d, got %0d", n.status, status);
      end
      if (offset !== n.offset) begin
        mismatches++;
        $error("end_offset: expected %0d, got %0d", n.offset, offset);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] char_in
  logic        s_axis_tuser = 1'b0; // [0] start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [31:0] value, [47:32] end_offset
  logic [1:0]  m_axis_tuser;        // [1:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  parse_tracker tracker = new();

  // Idle bursts on each stream are switched per phase of the run.
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned stall_left;
  int unsigned chars_sent, strings_sent, radix_writes;

  string_to_unsigned32_unit #(
    .POSITION_BITS(16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  // Result side: check every accepted result against the oldest owed number,
  // then decide whether to stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_number(m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[47:32]);
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      // Start a burst of random length with tready held low.
      stall_left = $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one character, maybe after an idle burst, and hold it until taken.
  task automatic send_char(input logic [7:0] c, input logic opens);
    int unsigned hold;
    hold = (send_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    if (hold != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= opens;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_char(c, opens);
    chars_sent++;
    if (opens) strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  // Drop valid, wait for every owed number, then let the pipeline drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the radix with a setup and an access cycle, only once the unit is idle.
  task automatic write_radix(input logic [BaseW-1:0] r);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RadixAddr;
    pwdata  <= 32'(r);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.radix = r;
    radix_writes++;
  endtask

  // Build one string: mostly well-formed numbers with random content, some noise
  // and some strings cut short so that the next start abandons them.
  task automatic send_number();
    logic [7:0]  text[$];
    logic [7:0]  letter;
    int unsigned base_now, count, d, w;
    string       stops;
    stops = " ,;).\n";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      base_now = (tracker.radix >= BinBase && tracker.radix <= MaxBase) ?
                 tracker.radix : DecBase;
      repeat ($urandom_range(0, 2)) begin
        w = $urandom_range(8, 13);
        text.push_back(w == 8 ? " " : 8'(w));
      end
      case ($urandom_range(0, 3))
        0: text.push_back("+");
        1: text.push_back("-");
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: begin
          text.push_back("0");
          text.push_back($urandom_range(0, 1) ? "x" : "X");
          base_now = HexBase;
        end
        1: begin
          text.push_back("0");
          text.push_back($urandom_range(0, 1) ? "b" : "B");
          base_now = BinBase;
        end
        2: begin
          text.push_back("0");
          if (tracker.radix == AutoBase) base_now = OctBase;
        end
        default: ;
      endcase
      // Long runs of digits can reach past the 32-bit range in every base.
      count = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (count) begin
        d = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 35) : $urandom_range(0, base_now - 1);
        letter = $urandom_range(0, 1) ? "a" : "A";
        text.push_back(d < 10 ? 8'("0" + d) : 8'(letter + d - 10));
      end
      if ($urandom_range(0, 7) != 0) begin
        text.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
                       8'(stops[$urandom_range(0, stops.len() - 1)]));
      end
    end
    if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
    foreach (text[i]) send_char(text[i], i == 0);
  endtask

  initial begin
    logic [BaseW-1:0] radix_plan[12];
    int unsigned      phase_mark;
    radix_plan = '{AutoBase, HexBase, BinBase, OctBase, MaxBase, BadLowBase,
                   6'd37, 6'd63, 6'd3, DecBase, AutoBase, 6'd25};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first string runs on the reset radix of ten.
    send_text("7,");
    write_radix(AutoBase);
    send_text("0X;");        // hex prefix with no digit after it
    send_text("09");         // lone zero, then a digit too large for octal
    send_char("Q", 1'b0);    // outside any string: ignored
    send_text("\v-0B1.");    // whitespace, minus, binary prefix
    send_char("+", 1'b1);
    send_char(8'hFF, 1'b0);  // high byte right after a sign
    send_char(8'h00, 1'b1);  // NUL as the whole string
    send_text("7");          // abandoned by the next start
    send_text("\t1a");
    send_text("9999999999 "); // overflow in decimal

    // Random part: one phase per radix setting, the last two without idle bursts.
    foreach (radix_plan[p]) begin
      write_radix(radix_plan[p]);
      send_idle  = (p < 10) && $urandom_range(0, 3) != 0;
      recv_idle  = (p < 10) && $urandom_range(0, 3) != 0;
      phase_mark = chars_sent;
      while (chars_sent - phase_mark < 50) send_number();
    end

    settle();
    $display("Sent %0d characters in %0d strings over %0d radix writes.",
             chars_sent, strings_sent, radix_writes);
    $display("Checked %0d results with %0d field mismatches.",
             tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Stop a hung run; the slowest correct run takes well under a millisecond.
  initial begin
    #5ms;
    $display("Run stopped at the time limit with %0d results still owed.",
             tracker.owed.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- string_to_unsigned32_unit.f -----
hw/rtl/stu_pkg.sv
hw/rtl/stu_front.sv
hw/rtl/stu_fifo.sv
hw/rtl/stu_back.sv
hw/rtl/string_to_unsigned32_unit.sv
bench/testbench.sv
